@@ rtl/gvc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_pkg: shared definitions for the greedy vertex clusterer
// Sizes, point layout helpers, controller states, datapath commands and the
// status bundle returned by the datapath.
// ----------------------------------------------------------------------------
package gvc_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CRD_W      = 16;
  localparam int PT_W       = 3 * CRD_W;
  localparam int ENT_W      = IDX_W + PT_W;
  localparam int OUT_IDX_W  = 5;
  localparam int GID_W      = 5;
  localparam int RAD_W      = 12;
  localparam int SMALL_W    = 7;
  localparam int CFG_A_W    = 2;
  localparam int CFG_D_W    = 12;
  localparam int IN_TDATA_W  = ((PT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_IDX_W + GID_W + 7) / 8) * 8;
  // Centroid arithmetic: sums of up to MAX_POINTS coordinates, scaled tests.
  localparam int SUM_W = CRD_W + IDX_W + 1;
  localparam int CD_W  = SUM_W + 2;
  localparam int CSQ_W = 2 * CD_W;
  localparam int CSS_W = CSQ_W + 2;
  localparam int LIM_W = CNT_W + RAD_W;
  // Point-to-member distance.
  localparam int MD_W  = CRD_W + 1;
  localparam int MSQ_W = 2 * MD_W;
  localparam int MSS_W = MSQ_W + 2;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_LINK_RADIUS    = 2'd0,
    CFG_CENTROID_LIMIT = 2'd1,
    CFG_SMALL_SIZE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SORT_RI, ST_SORT_RJ, ST_SORT_CMP, ST_SORT_WR,
    ST_SEED, ST_SEED_ADD, ST_SCAN, ST_PT_LD,
    ST_CEN_MUL, ST_CEN_SQ, ST_CEN_CMP,
    ST_MEM_RD, ST_MEM_DIFF, ST_MEM_SQ, ST_MEM_CMP, ST_ADD,
    ST_EMIT_RD, ST_EMIT_OUT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_SORT_RD_I, OP_SORT_LD_I, OP_SORT_CMP, OP_SORT_WR,
    OP_SEED_SKIP, OP_SEED_RD, OP_SEED_ADD, OP_SCAN_SKIP, OP_SCAN_RD,
    OP_PT_LD, OP_CEN_MUL, OP_CEN_SQ, OP_MEM_RD, OP_MEM_DIFF, OP_MEM_SQ,
    OP_MEM_NEXT, OP_REJECT, OP_ADD, OP_EMIT_INIT, OP_EMIT_OUT, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic sort_j_last;
    logic sort_i_last;
    logic seed_done;
    logic seed_used;
    logic scan_done;
    logic scan_used;
    logic over_small;
    logic cen_ok;
    logic near;
    logic mem_last;
    logic out_free;
  } dp_sts_t;

  // Coordinate k of a packed point: x, y, z from the lowest bits up.
  function automatic logic signed [CRD_W-1:0] crd(input logic [PT_W-1:0] pt,
                                                  input int k);
    crd = pt[k*CRD_W +: CRD_W];
  endfunction

  // True when point a sorts strictly before point b (z, then x, then y).
  function automatic logic pt_less(input logic [PT_W-1:0] a,
                                   input logic [PT_W-1:0] b);
    logic r;
    r = 1'b0;
    if (crd(a, 2) != crd(b, 2)) begin
      r = crd(a, 2) < crd(b, 2);
    end else if (crd(a, 0) != crd(b, 0)) begin
      r = crd(a, 0) < crd(b, 0);
    end else begin
      r = crd(a, 1) < crd(b, 1);
    end
    pt_less = r;
  endfunction

endpackage

@@ rtl/greedy_vertex_clusterer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_vertex_clusterer: top level
// Collects a set of 3D points, sorts them by z, x, y and groups them into
// clusters greedily; emits one item per point, grouped by cluster.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  in_     | slave     | tdata = pos_x, pos_y, pos_z; tlast = final_point
//  out_    | master    | tdata = point_index, group_id; tlast = group_end;
//          |           | tuser = set_end, dropped
//  cfg_    | write     | link_radius, centroid_limit, small_cluster_size
//
// After the final point the sequencer ranks the points. Each cluster pass
// then visits every sorted point, loads each unused candidate, runs the
// centroid test once the cluster is past the small size and checks the
// candidate against the members; each result is then emitted in turn.
// Reset is synchronous, active low. A stalled output holds the sequencer;
// input is taken only between sets.
// ----------------------------------------------------------------------------
module greedy_vertex_clusterer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gvc_pkg::IN_TDATA_W-1:0]      in_tdata,  // pos_x, pos_y, pos_z
  input  logic                                in_tlast,  // final_point
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gvc_pkg::OUT_TDATA_W-1:0]     out_tdata, // point_index, group_id
  output logic                                out_tlast, // group_end
  output logic [1:0]                          out_tuser, // set_end, dropped
  input  logic                                cfg_we,
  input  logic [gvc_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [gvc_pkg::CFG_D_W-1:0]         cfg_wdata
);

  gvc_pkg::dp_op_t  op;
  gvc_pkg::dp_sts_t sts;
  logic [gvc_pkg::OUT_IDX_W-1:0] out_index;
  logic [gvc_pkg::GID_W-1:0]     out_gid;

  gvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .op        (op)
  );

  gvc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .sts       (sts),
    .in_pt     (in_tdata[gvc_pkg::PT_W-1:0]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (out_index),
    .out_gid   (out_gid),
    .out_gend  (out_tlast),
    .out_send  (out_tuser[0]),
    .out_drop  (out_tuser[1])
  );

  assign out_tdata = gvc_pkg::OUT_TDATA_W'({out_gid, out_index});

  // The end of a set is always the end of a cluster.
  a_set_end_is_group_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("set end without group end");

  // The final point starts clustering, so no input is taken right after it.
  a_busy_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken while clustering");

  // A result is only loaded when the output register is free.
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    op == gvc_pkg::OP_EMIT_OUT |-> (!out_tvalid || out_tready))
    else $error("output overwritten");

endmodule

@@ rtl/gvc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_ctrl: sequencer of the clusterer
// Walks load, rank sort, greedy cluster passes and emission, issuing one
// datapath command per cycle from the datapath status.
// ----------------------------------------------------------------------------
module gvc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  gvc_pkg::dp_sts_t sts,
  output gvc_pkg::dp_op_t  op
);

  gvc_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gvc_pkg::ST_IDLE: begin
        if (in_tvalid && in_tlast) state_nxt = gvc_pkg::ST_SORT_RI;
      end
      gvc_pkg::ST_SORT_RI:  state_nxt = gvc_pkg::ST_SORT_RJ;
      gvc_pkg::ST_SORT_RJ:  state_nxt = gvc_pkg::ST_SORT_CMP;
      gvc_pkg::ST_SORT_CMP: begin
        if (sts.sort_j_last) state_nxt = gvc_pkg::ST_SORT_WR;
      end
      gvc_pkg::ST_SORT_WR: begin
        state_nxt = sts.sort_i_last ? gvc_pkg::ST_SEED : gvc_pkg::ST_SORT_RI;
      end
      gvc_pkg::ST_SEED: begin
        if (sts.seed_done) state_nxt = gvc_pkg::ST_IDLE;
        else if (!sts.seed_used) state_nxt = gvc_pkg::ST_SEED_ADD;
      end
      gvc_pkg::ST_SEED_ADD: state_nxt = gvc_pkg::ST_SCAN;
      gvc_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = gvc_pkg::ST_EMIT_RD;
        else if (!sts.scan_used) state_nxt = gvc_pkg::ST_PT_LD;
      end
      gvc_pkg::ST_PT_LD: begin
        state_nxt = sts.over_small ? gvc_pkg::ST_CEN_MUL : gvc_pkg::ST_MEM_RD;
      end
      gvc_pkg::ST_CEN_MUL: state_nxt = gvc_pkg::ST_CEN_SQ;
      gvc_pkg::ST_CEN_SQ:  state_nxt = gvc_pkg::ST_CEN_CMP;
      gvc_pkg::ST_CEN_CMP: begin
        state_nxt = sts.cen_ok ? gvc_pkg::ST_MEM_RD : gvc_pkg::ST_SCAN;
      end
      gvc_pkg::ST_MEM_RD:   state_nxt = gvc_pkg::ST_MEM_DIFF;
      gvc_pkg::ST_MEM_DIFF: state_nxt = gvc_pkg::ST_MEM_SQ;
      gvc_pkg::ST_MEM_SQ:   state_nxt = gvc_pkg::ST_MEM_CMP;
      gvc_pkg::ST_MEM_CMP: begin
        if (sts.near) state_nxt = gvc_pkg::ST_ADD;
        else if (sts.mem_last) state_nxt = gvc_pkg::ST_SCAN;
        else state_nxt = gvc_pkg::ST_MEM_RD;
      end
      gvc_pkg::ST_ADD:     state_nxt = gvc_pkg::ST_SCAN;
      gvc_pkg::ST_EMIT_RD: state_nxt = gvc_pkg::ST_EMIT_OUT;
      gvc_pkg::ST_EMIT_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.mem_last ? gvc_pkg::ST_SEED : gvc_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = gvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op        = gvc_pkg::OP_NOP;
    in_tready = 1'b0;
    unique case (state_r)
      gvc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) op = gvc_pkg::OP_LOAD;
      end
      gvc_pkg::ST_SORT_RI:  op = gvc_pkg::OP_SORT_RD_I;
      gvc_pkg::ST_SORT_RJ:  op = gvc_pkg::OP_SORT_LD_I;
      gvc_pkg::ST_SORT_CMP: op = gvc_pkg::OP_SORT_CMP;
      gvc_pkg::ST_SORT_WR:  op = gvc_pkg::OP_SORT_WR;
      gvc_pkg::ST_SEED: begin
        if (sts.seed_done) op = gvc_pkg::OP_FINISH;
        else if (sts.seed_used) op = gvc_pkg::OP_SEED_SKIP;
        else op = gvc_pkg::OP_SEED_RD;
      end
      gvc_pkg::ST_SEED_ADD: op = gvc_pkg::OP_SEED_ADD;
      gvc_pkg::ST_SCAN: begin
        if (sts.scan_done) op = gvc_pkg::OP_EMIT_INIT;
        else if (sts.scan_used) op = gvc_pkg::OP_SCAN_SKIP;
        else op = gvc_pkg::OP_SCAN_RD;
      end
      gvc_pkg::ST_PT_LD:   op = gvc_pkg::OP_PT_LD;
      gvc_pkg::ST_CEN_MUL: op = gvc_pkg::OP_CEN_MUL;
      gvc_pkg::ST_CEN_SQ:  op = gvc_pkg::OP_CEN_SQ;
      gvc_pkg::ST_CEN_CMP: begin
        if (!sts.cen_ok) op = gvc_pkg::OP_REJECT;
      end
      gvc_pkg::ST_MEM_RD:   op = gvc_pkg::OP_MEM_RD;
      gvc_pkg::ST_MEM_DIFF: op = gvc_pkg::OP_MEM_DIFF;
      gvc_pkg::ST_MEM_SQ:   op = gvc_pkg::OP_MEM_SQ;
      gvc_pkg::ST_MEM_CMP: begin
        if (sts.near) op = gvc_pkg::OP_NOP;
        else if (sts.mem_last) op = gvc_pkg::OP_REJECT;
        else op = gvc_pkg::OP_MEM_NEXT;
      end
      gvc_pkg::ST_ADD:     op = gvc_pkg::OP_ADD;
      gvc_pkg::ST_EMIT_RD: op = gvc_pkg::OP_MEM_RD;
      gvc_pkg::ST_EMIT_OUT: begin
        if (sts.out_free) op = gvc_pkg::OP_EMIT_OUT;
      end
      default: op = gvc_pkg::OP_NOP;
    endcase
  end

endmodule

@@ rtl/gvc_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_dpath: storage and arithmetic of the clusterer
// Point, sorted and member memories, loop counters, distance and centroid
// arithmetic, configuration registers and the output register.
// ----------------------------------------------------------------------------
module gvc_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gvc_pkg::dp_op_t                   op,
  output gvc_pkg::dp_sts_t                  sts,
  input  logic [gvc_pkg::PT_W-1:0]          in_pt,
  input  logic                              cfg_we,
  input  logic [gvc_pkg::CFG_A_W-1:0]       cfg_addr,
  input  logic [gvc_pkg::CFG_D_W-1:0]       cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gvc_pkg::OUT_IDX_W-1:0]     out_index,
  output logic [gvc_pkg::GID_W-1:0]         out_gid,
  output logic                              out_gend,
  output logic                              out_send,
  output logic                              out_drop
);

  localparam int IW = gvc_pkg::IDX_W;
  localparam int CW = gvc_pkg::CNT_W;
  localparam int PW = gvc_pkg::PT_W;

  // Configuration.
  logic [gvc_pkg::RAD_W-1:0]   link_r, cent_r;
  logic [gvc_pkg::SMALL_W-1:0] small_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= gvc_pkg::RAD_W'(40);
      cent_r  <= gvc_pkg::RAD_W'(80);
      small_r <= gvc_pkg::SMALL_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gvc_pkg::CFG_LINK_RADIUS:    link_r  <= cfg_wdata[gvc_pkg::RAD_W-1:0];
        gvc_pkg::CFG_CENTROID_LIMIT: cent_r  <= cfg_wdata[gvc_pkg::RAD_W-1:0];
        gvc_pkg::CFG_SMALL_SIZE:     small_r <= cfg_wdata[gvc_pkg::SMALL_W-1:0];
        default: ;
      endcase
    end
  end

  // Control counters.
  logic [CW-1:0] cnt_r, i_r, j_r, o_r, m_r, rank_r, nmem_r;
  logic [gvc_pkg::GID_W-1:0] gid_r;
  logic ovf_r;
  logic [gvc_pkg::MAX_POINTS-1:0] used_r, live;
  logic full, less;

  // Memories.
  logic [PW-1:0] pts_mem [gvc_pkg::MAX_POINTS];
  logic [gvc_pkg::ENT_W-1:0] spt_mem [gvc_pkg::MAX_POINTS];
  logic [gvc_pkg::ENT_W-1:0] mbr_mem [gvc_pkg::MAX_POINTS];
  logic [PW-1:0] pts_rd_r, pi_r;
  logic [gvc_pkg::ENT_W-1:0] spt_rd_r, mbr_rd_r, p_r;
  logic [IW-1:0] pts_addr, spt_addr;

  assign full = (cnt_r == CW'(gvc_pkg::MAX_POINTS));

  always_comb begin
    case (op)
      gvc_pkg::OP_SORT_RD_I: pts_addr = i_r[IW-1:0];
      gvc_pkg::OP_SORT_LD_I: pts_addr = '0;
      default:               pts_addr = IW'(j_r + CW'(1));
    endcase
    spt_addr = (op == gvc_pkg::OP_SEED_RD) ? o_r[IW-1:0] : i_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (op == gvc_pkg::OP_LOAD && !full) pts_mem[cnt_r[IW-1:0]] <= in_pt;
    pts_rd_r <= pts_mem[pts_addr];
  end

  always_ff @(posedge clk) begin
    if (op == gvc_pkg::OP_SORT_WR) spt_mem[rank_r[IW-1:0]] <= {i_r[IW-1:0], pi_r};
    spt_rd_r <= spt_mem[spt_addr];
  end

  always_ff @(posedge clk) begin
    if (op == gvc_pkg::OP_SEED_ADD) mbr_mem[0] <= spt_rd_r;
    else if (op == gvc_pkg::OP_ADD) mbr_mem[nmem_r[IW-1:0]] <= p_r;
    mbr_rd_r <= mbr_mem[m_r[IW-1:0]];
  end

  // Stable rank: earlier points with an equal key rank lower.
  assign less = gvc_pkg::pt_less(pts_rd_r, pi_r) ||
                ((pts_rd_r == pi_r) && (j_r < i_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      i_r    <= '0;
      j_r    <= '0;
      o_r    <= '0;
      m_r    <= '0;
      rank_r <= '0;
      nmem_r <= '0;
      gid_r  <= '0;
      ovf_r  <= 1'b0;
      used_r <= '0;
    end else begin
      case (op) inside
        gvc_pkg::OP_LOAD: begin
          if (full) ovf_r <= 1'b1;
          else cnt_r <= cnt_r + CW'(1);
        end
        gvc_pkg::OP_SORT_LD_I: begin
          j_r    <= '0;
          rank_r <= '0;
        end
        gvc_pkg::OP_SORT_CMP: begin
          j_r <= j_r + CW'(1);
          if (less) rank_r <= rank_r + CW'(1);
        end
        gvc_pkg::OP_SORT_WR:   i_r <= i_r + CW'(1);
        gvc_pkg::OP_SEED_SKIP: o_r <= o_r + CW'(1);
        gvc_pkg::OP_SEED_ADD: begin
          nmem_r <= CW'(1);
          used_r[o_r[IW-1:0]] <= 1'b1;
          i_r <= '0;
        end
        gvc_pkg::OP_SCAN_SKIP, gvc_pkg::OP_REJECT: i_r <= i_r + CW'(1);
        gvc_pkg::OP_PT_LD, gvc_pkg::OP_EMIT_INIT:  m_r <= '0;
        gvc_pkg::OP_MEM_NEXT: m_r <= m_r + CW'(1);
        gvc_pkg::OP_ADD: begin
          nmem_r <= nmem_r + CW'(1);
          used_r[i_r[IW-1:0]] <= 1'b1;
          i_r <= i_r + CW'(1);
        end
        gvc_pkg::OP_EMIT_OUT: begin
          m_r <= m_r + CW'(1);
          if (sts.mem_last) gid_r <= gid_r + gvc_pkg::GID_W'(1);
        end
        gvc_pkg::OP_FINISH: begin
          cnt_r  <= '0;
          i_r    <= '0;
          o_r    <= '0;
          gid_r  <= '0;
          ovf_r  <= 1'b0;
          used_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == gvc_pkg::OP_SORT_LD_I) pi_r <= pts_rd_r;
    if (op == gvc_pkg::OP_PT_LD) p_r <= spt_rd_r;
  end

  // Centroid test: |S - n*p|^2 <= (n*L)^2.
  logic signed [gvc_pkg::SUM_W-1:0] sums_r [3];
  logic signed [gvc_pkg::CD_W-1:0]  cd_r [3];
  logic [gvc_pkg::CSQ_W-1:0]        csq_r [3];
  logic [gvc_pkg::LIM_W-1:0]        lim_r;
  logic [2*gvc_pkg::LIM_W-1:0]      lim2_r;
  logic signed [CW:0]               n_s;
  // Member test: |p - q|^2 <= R^2.
  logic signed [gvc_pkg::MD_W-1:0]  md_r [3];
  logic [gvc_pkg::MSQ_W-1:0]        msq_r [3];
  logic [2*gvc_pkg::RAD_W-1:0]      r2_r;

  assign n_s = {1'b0, nmem_r};

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (op == gvc_pkg::OP_SEED_ADD) begin
        sums_r[k] <= gvc_pkg::SUM_W'(gvc_pkg::crd(spt_rd_r[PW-1:0], k));
      end else if (op == gvc_pkg::OP_ADD) begin
        sums_r[k] <= sums_r[k] + gvc_pkg::SUM_W'(gvc_pkg::crd(p_r[PW-1:0], k));
      end
      if (op == gvc_pkg::OP_CEN_MUL) begin
        cd_r[k] <= gvc_pkg::CD_W'(sums_r[k]) -
                   gvc_pkg::CD_W'(n_s * gvc_pkg::crd(p_r[PW-1:0], k));
      end
      if (op == gvc_pkg::OP_CEN_SQ) csq_r[k] <= gvc_pkg::CSQ_W'(cd_r[k] * cd_r[k]);
      if (op == gvc_pkg::OP_MEM_DIFF) begin
        md_r[k] <= gvc_pkg::MD_W'(gvc_pkg::crd(p_r[PW-1:0], k)) -
                   gvc_pkg::MD_W'(gvc_pkg::crd(mbr_rd_r[PW-1:0], k));
      end
      if (op == gvc_pkg::OP_MEM_SQ) msq_r[k] <= gvc_pkg::MSQ_W'(md_r[k] * md_r[k]);
    end
    if (op == gvc_pkg::OP_CEN_MUL) lim_r <= gvc_pkg::LIM_W'(nmem_r * cent_r);
    if (op == gvc_pkg::OP_CEN_SQ) lim2_r <= lim_r * lim_r;
    if (op == gvc_pkg::OP_MEM_SQ) r2_r <= link_r * link_r;
  end

  always_comb begin
    for (int k = 0; k < gvc_pkg::MAX_POINTS; k++) begin
      live[k] = (CW'(k) < cnt_r);
    end
  end

  // Output register.
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == gvc_pkg::OP_EMIT_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == gvc_pkg::OP_EMIT_OUT) begin
      out_index <= gvc_pkg::OUT_IDX_W'(mbr_rd_r[gvc_pkg::ENT_W-1:PW]);
      out_gid   <= gid_r;
      out_gend  <= sts.mem_last;
      // The set ends with the last member of the cluster that uses up all points.
      out_send  <= sts.mem_last && ((used_r | ~live) == '1);
      out_drop  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.sort_j_last = (j_r == cnt_r - CW'(1));
    sts.sort_i_last = (i_r == cnt_r - CW'(1));
    sts.seed_done   = (o_r == cnt_r);
    sts.seed_used   = used_r[o_r[IW-1:0]];
    sts.scan_done   = (i_r == cnt_r);
    sts.scan_used   = used_r[i_r[IW-1:0]];
    sts.over_small  = (gvc_pkg::SMALL_W'(nmem_r) > small_r);
    sts.cen_ok      = (gvc_pkg::CSS_W'(csq_r[0]) + gvc_pkg::CSS_W'(csq_r[1]) +
                       gvc_pkg::CSS_W'(csq_r[2])) <= gvc_pkg::CSS_W'(lim2_r);
    sts.near        = (gvc_pkg::MSS_W'(msq_r[0]) + gvc_pkg::MSS_W'(msq_r[1]) +
                       gvc_pkg::MSS_W'(msq_r[2])) <= gvc_pkg::MSS_W'(r2_r);
    sts.mem_last    = (CW'(m_r + CW'(1)) == nmem_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule

@@ tb/greedy_vertex_clusterer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_vertex_clusterer_test: self-checking bench for the vertex clusterer
// Streams sets of 3D points into the block and predicts the ordered cluster
// membership items it must return. Directed sets cover extreme coordinates
// and equal sort keys. Random sets use tight and loose point clouds, some
// beyond capacity, under several radius, limit and size settings, with random
// idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module greedy_vertex_clusterer_test;

  typedef struct {
    logic [4:0] point_index;
    logic [4:0] group_id;
    logic       group_end;
    logic       set_end;
    logic       dropped;
  } member_item_t;

  class cluster_board;
    longint       pts[gvc_pkg::MAX_POINTS][3];
    int           n_pts;
    bit           overflow;
    longint       radius, cen_limit, small_size;
    member_item_t expected_q[$];
    int           n_sets, n_points, n_checked, n_errors;

    function new();
      radius = 40;
      cen_limit = 80;
      small_size = 5;
    endfunction

    function void set_reg(gvc_pkg::cfg_idx_t idx, int val);
      case (idx)
        gvc_pkg::CFG_LINK_RADIUS:    radius = val & 12'hFFF;
        gvc_pkg::CFG_CENTROID_LIMIT: cen_limit = val & 12'hFFF;
        gvc_pkg::CFG_SMALL_SIZE:     small_size = val & 7'h7F;
        default: ;
      endcase
    endfunction

    function longint dist_sq(int a, int b);
      longint s;
      s = 0;
      for (int k = 0; k < 3; k++) s += (pts[a][k] - pts[b][k]) * (pts[a][k] - pts[b][k]);
      return s;
    endfunction

    // z first, then x, then y.
    function bit sorts_before(int a, int b);
      if (pts[a][2] != pts[b][2]) return pts[a][2] < pts[b][2];
      if (pts[a][0] != pts[b][0]) return pts[a][0] < pts[b][0];
      return pts[a][1] < pts[b][1];
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit last);
      int     order[gvc_pkg::MAX_POINTS];
      bit     used[gvc_pkg::MAX_POINTS];
      int     members[gvc_pkg::MAX_POINTS];
      int     n_mem, j, v, p, gid;
      longint sums[3];
      longint d, lim;
      bit     near;
      member_item_t r;
      n_points++;
      if (n_pts < gvc_pkg::MAX_POINTS) begin
        pts[n_pts][0] = x;
        pts[n_pts][1] = y;
        pts[n_pts][2] = z;
        n_pts++;
      end else begin
        overflow = 1;
      end
      if (!last) return;
      n_sets++;
      // Stable insertion sort keeps equal keys in arrival order.
      for (int i = 0; i < n_pts; i++) begin
        v = i;
        j = i;
        while (j > 0 && sorts_before(v, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
        used[i] = 0;
      end
      gid = 0;
      for (int o = 0; o < n_pts; o++) begin
        if (used[order[o]]) continue;
        n_mem = 1;
        members[0] = order[o];
        used[order[o]] = 1;
        for (int k = 0; k < 3; k++) sums[k] = pts[order[o]][k];
        for (int i = 0; i < n_pts; i++) begin
          p = order[i];
          if (used[p]) continue;
          near = 0;
          for (int m = 0; m < n_mem; m++)
            if (dist_sq(p, members[m]) <= radius * radius) near = 1;
          if (n_mem > small_size && near) begin
            d = 0;
            for (int k = 0; k < 3; k++)
              d += (sums[k] - n_mem * pts[p][k]) * (sums[k] - n_mem * pts[p][k]);
            lim = n_mem * cen_limit;
            near = (d <= lim * lim);
          end
          if (near) begin
            members[n_mem++] = p;
            used[p] = 1;
            for (int k = 0; k < 3; k++) sums[k] += pts[p][k];
          end
        end
        for (int m = 0; m < n_mem; m++) begin
          r.point_index = members[m][4:0];
          r.group_id    = gid[4:0];
          r.group_end   = (m == n_mem - 1);
          r.set_end     = 0;
          r.dropped     = overflow;
          expected_q = {expected_q, r};
        end
        gid++;
      end
      expected_q[expected_q.size()-1].set_end = 1;
      n_pts = 0;
      overflow = 0;
    endfunction

    function void check_item(member_item_t got);
      member_item_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected output item: point_index %0d group_id %0d",
               got.point_index, got.group_id);
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.point_index !== e.point_index) begin
        $error("point_index: expected %0d, actual %0d", e.point_index, got.point_index);
        n_errors++;
      end
      if (got.group_id !== e.group_id) begin
        $error("group_id: expected %0d, actual %0d", e.group_id, got.group_id);
        n_errors++;
      end
      if (got.group_end !== e.group_end) begin
        $error("group_end: expected %0d, actual %0d", e.group_end, got.group_end);
        n_errors++;
      end
      if (got.set_end !== e.set_end) begin
        $error("set_end: expected %0d, actual %0d", e.set_end, got.set_end);
        n_errors++;
      end
      if (got.dropped !== e.dropped) begin
        $error("dropped: expected %0d, actual %0d", e.dropped, got.dropped);
        n_errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [gvc_pkg::IN_TDATA_W-1:0]  in_tdata;   // pos_x, pos_y, pos_z
  logic                            in_tlast;   // final_point
  logic                            out_tvalid;
  logic                            out_tready;
  logic [gvc_pkg::OUT_TDATA_W-1:0] out_tdata;  // point_index, group_id
  logic                            out_tlast;  // group_end
  logic [1:0]                      out_tuser;  // set_end, dropped
  logic                            cfg_we;
  logic [gvc_pkg::CFG_A_W-1:0]     cfg_addr;
  logic [gvc_pkg::CFG_D_W-1:0]     cfg_wdata;

  cluster_board board;
  int           send_idle;
  int           recv_idle;
  bit           stall_req;
  int           stall_left;

  greedy_vertex_clusterer DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  // Output side: random backpressure plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      member_item_t got;
      got.point_index = out_tdata[4:0];
      got.group_id    = out_tdata[9:5];
      got.group_end   = out_tlast;
      got.set_end     = out_tuser[0];
      got.dropped     = out_tuser[1];
      board.check_item(got);
    end
    if (stall_req) begin
      stall_left <= 600;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_regs(int rad, int lim, int small_sz);
    cfg_we <= 1'b1;
    cfg_addr <= gvc_pkg::CFG_LINK_RADIUS;
    cfg_wdata <= gvc_pkg::CFG_D_W'(rad);
    @(posedge clk);
    cfg_addr <= gvc_pkg::CFG_CENTROID_LIMIT;
    cfg_wdata <= gvc_pkg::CFG_D_W'(lim);
    @(posedge clk);
    cfg_addr <= gvc_pkg::CFG_SMALL_SIZE;
    cfg_wdata <= gvc_pkg::CFG_D_W'(small_sz);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(gvc_pkg::CFG_LINK_RADIUS, rad);
    board.set_reg(gvc_pkg::CFG_CENTROID_LIMIT, lim);
    board.set_reg(gvc_pkg::CFG_SMALL_SIZE, small_sz);
  endtask

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_point(x, y, z, last);
  endtask

  // The block keeps skipping used seeds after its last item, so wait
  // past that before touching settings.
  task automatic drain();
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Points scattered around a random center; a wide spread or a full-range
  // cloud yields mostly single-member clusters.
  task automatic send_cloud(int n);
    logic [15:0] cx, cy, cz;
    int spread, pick;
    pick = $urandom_range(4);
    spread = (pick == 0) ? 0 : (pick == 1) ? 4 : (pick == 2) ? 30 : 200;
    cx = 16'($urandom);
    cy = 16'($urandom);
    cz = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if (pick == 4)
        send_point(16'($urandom), 16'($urandom), 16'($urandom), i == n - 1);
      else
        send_point(16'(cx + $urandom_range(2 * spread) - spread),
                   16'(cy + $urandom_range(2 * spread) - spread),
                   16'(cz + $urandom_range(2 * spread) - spread), i == n - 1);
    end
  endtask

  task automatic random_sets(int n_items);
    int sent, n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(14) == 0) begin
        n = $urandom_range(gvc_pkg::MAX_POINTS, gvc_pkg::MAX_POINTS + 3);
      end else begin
        n = $urandom_range(1, 12);
      end
      send_cloud(n);
      sent += n;
    end
    in_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    board = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    out_tready = 0;
    cfg_we = 0;
    cfg_addr = gvc_pkg::CFG_LINK_RADIUS;
    cfg_wdata = '0;
    stall_req = 0;
    stall_left = 0;
    send_idle = 0;
    recv_idle = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets under the reset settings.
    send_point(16'h8000, 16'h8000, 16'h8000, 1);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
    send_point(16'h8000, 16'h7FFF, 16'h0000, 0);
    send_point(16'h7FFF, 16'h8000, 16'hFFFF, 1);
    // Equal keys must keep arrival order; one distinct point in between.
    send_point(16'd10, 16'd20, 16'd30, 0);
    send_point(16'd10, 16'd20, 16'd30, 0);
    send_point(16'd12, 16'd20, 16'd29, 0);
    send_point(16'd10, 16'd20, 16'd30, 1);
    // Descending z with equal z broken by x, then y.
    send_point(16'd0, 16'd0, 16'd50, 0);
    send_point(16'd5, 16'd0, 16'd20, 0);
    send_point(16'd5, 16'hFFFF, 16'd20, 0);
    send_point(16'hFFFB, 16'd0, 16'd20, 0);
    send_point(16'd0, 16'd0, 16'd0, 1);
    in_tvalid <= 1'b0;
    drain();
    // A chain that grows past the small size exercises the centroid test.
    write_regs(20, 10, 2);
    for (int i = 0; i < 8; i++) send_point(16'(i * 15), 16'd0, 16'd0, i == 7);
    in_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 53 : 0;
      recv_idle = (ph == 0) ? 53 : (ph == 1) ? 31 : 0;
      case (ph)
        0: write_regs(0, 0, 0);
        1: write_regs(4095, 4095, 64);
        default: write_regs(40, 80, 5);
      endcase
      if (ph == 2) begin
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
      end
      random_sets(55);
      case (ph)
        0: write_regs(60, 25, 1);
        1: write_regs(600, 150, 3);
        default: write_regs(12, 4095, 64);
      endcase
      random_sets(55);
    end

    $display("Covered %0d point sets, %0d points in, %0d member items checked,",
             board.n_sets, board.n_points, board.n_checked);
    $display("including overflowing sets, equal keys and extreme register values.");
    if (board.n_errors == 0 && board.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gvc_pkg.sv
rtl/gvc_ctrl.sv
rtl/gvc_dpath.sv
rtl/greedy_vertex_clusterer.sv
tb/greedy_vertex_clusterer_test.sv
